/* rtl/hts_pkg.sv */
package hts_pkg;

    localparam int unsigned LOOKAHEAD_DEF = 10;
    localparam int unsigned PEEK_N        = 9;
    localparam int unsigned PAT_W         = 72;
    localparam int unsigned ENT_N         = 10;

    typedef logic [7:0] t_byte;
    typedef logic [PEEK_N-1:0][7:0] t_peek;

    typedef struct packed {
        logic full;
        logic empty;
        logic flush;
    } t_win_status;

    typedef struct packed {
        logic  has_char;
        t_byte ch;
    } t_result;

    localparam t_byte CH_LT    = 8'h3C;
    localparam t_byte CH_GT    = 8'h3E;
    localparam t_byte CH_SLASH = 8'h2F;
    localparam t_byte CH_QUOTE = 8'h22;
    localparam t_byte CH_EQ    = 8'h3D;
    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_DEL   = 8'h7F;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_STAR  = 8'h2A;
    localparam t_byte CH_UNDER = 8'h5F;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;

    localparam logic [PAT_W-1:0] ENT_NAME [ENT_N] = '{
        "nbsp", "brvbar", "laquo", "shy", "raquo",
        "divide", "quot", "amp", "lt", "gt"
    };
    localparam int unsigned ENT_LEN [ENT_N] = '{4, 6, 5, 3, 5, 6, 4, 3, 2, 2};
    localparam t_byte ENT_REP [ENT_N] = '{
        8'h20, 8'h7C, 8'h3C, 8'h2D, 8'h3E, 8'h2F, 8'h22, 8'h26, 8'h3C, 8'h3E
    };

    function automatic t_byte upcase(t_byte c);
        t_byte r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // Patterns are right aligned string literals, first character highest.
    function automatic logic match_at(t_peek pk, int unsigned off,
                                      logic [PAT_W-1:0] pat, int unsigned len);
        logic ok;
        ok = 1'b1;
        for (int unsigned k = 0; k < PEEK_N; k++) begin
            if (k < len) begin
                if (off + k >= PEEK_N) begin
                    ok = 1'b0;
                end else if (upcase(pk[off+k]) != upcase(pat[8*(len-1-k) +: 8])) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    function automatic logic is_blank(t_byte c);
        return (c < 8'd32) || (c == CH_DEL) || (c == CH_SPACE);
    endfunction

endpackage

/* rtl/html_tag_stripper_top.sv */
// Html tag stripper: turns a stream of message text bytes into plain text.
// Input channel: one text byte per request on i_s_tdata, with i_s_tlast on
// the final byte of a text. Output channel: one cleaned byte per request on
// o_m_tdata with o_m_tuser set; a text ends with a bare end marker that has
// o_m_tlast set and o_m_tuser and o_m_tdata clear.
// Each byte is decided once the lookahead window of LOOKAHEAD bytes behind
// it is filled or its text has ended, so mid-text the result for a byte
// appears after LOOKAHEAD - 1 more bytes have been taken. The decision is a
// single registered pass over the window, so one byte is taken every cycle
// while the receiver keeps i_m_tready high.
// After a byte with i_s_tlast the block takes no input while the window
// drains its held bytes and then issues the end marker, and all mode state
// then returns to its reset values for the next text.
// Reset empties the window, clears the mode flags and the output valid flag.
// When the receiver stalls, the output register holds its request and the
// window stops advancing; input is still taken until the window is full.
module html_tag_stripper_top #(
    parameter int unsigned LOOKAHEAD = hts_pkg::LOOKAHEAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,  // [7:0] out_byte
    output logic [0:0] o_m_tuser,  // [0] out_valid
    output logic       o_m_tlast
);

    hts_pkg::t_peek       peek;
    hts_pkg::t_win_status status;
    hts_pkg::t_result     res;

    logic slot_free;
    logic adv;
    logic end_go;
    logic push;

    logic           r_o_valid;
    hts_pkg::t_byte r_o_data;
    logic           r_o_user;
    logic           r_o_last;

    assign slot_free  = !r_o_valid || i_m_tready;
    assign adv        = slot_free && !status.empty && (status.full || status.flush);
    assign end_go     = slot_free && status.flush && status.empty;
    assign o_s_tready = !status.flush && (!status.full || adv);
    assign push       = i_s_tvalid && o_s_tready;

    hts_window #(
        .LOOKAHEAD(LOOKAHEAD)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_adv    (adv),
        .i_clear  (end_go),
        .o_peek   (peek),
        .o_status (status)
    );

    hts_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_clear (end_go),
        .i_peek  (peek),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (end_go || (adv && res.has_char)) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_go) begin
            r_o_data <= 8'h00;
            r_o_user <= 1'b0;
            r_o_last <= 1'b1;
        end else if (adv && res.has_char) begin
            r_o_data <= res.ch;
            r_o_user <= 1'b1;
            r_o_last <= 1'b0;
        end
    end

    assign o_m_tvalid   = r_o_valid;
    assign o_m_tdata    = r_o_data;
    assign o_m_tuser[0] = r_o_user;
    assign o_m_tlast    = r_o_last;

    a_end_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == 8'h00) && !o_m_tuser[0])
        else $error("end marker carries a character");

endmodule

/* rtl/hts_window.sv */
module hts_window #(
    parameter int unsigned LOOKAHEAD = hts_pkg::LOOKAHEAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hts_pkg::t_byte      i_byte,
    input  logic                i_last,
    input  logic                i_adv,
    input  logic                i_clear,
    output hts_pkg::t_peek      o_peek,
    output hts_pkg::t_win_status o_status
);

    localparam int unsigned CW = $clog2(LOOKAHEAD + 1);

    hts_pkg::t_byte r_win [LOOKAHEAD];
    hts_pkg::t_byte n_win [LOOKAHEAD];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  wpos;
    logic           r_flush;

    always_comb begin
        wpos = r_count;
        if (i_adv) begin
            wpos = r_count - CW'(1);
        end
        for (int unsigned k = 0; k < LOOKAHEAD - 1; k++) begin
            n_win[k] = i_adv ? r_win[k+1] : r_win[k];
        end
        n_win[LOOKAHEAD-1] = i_adv ? 8'h00 : r_win[LOOKAHEAD-1];
        for (int unsigned k = 0; k < LOOKAHEAD; k++) begin
            if (i_push && wpos == CW'(k)) begin
                n_win[k] = i_byte;
            end
        end
        n_count = r_count - CW'(i_adv) + CW'(i_push);
    end

    always_ff @(posedge i_clk) begin
        for (int unsigned k = 0; k < LOOKAHEAD; k++) begin
            r_win[k] <= n_win[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flush <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_clear) begin
                r_flush <= 1'b0;
            end else if (i_push && i_last) begin
                r_flush <= 1'b1;
            end
        end
    end

    always_comb begin
        for (int unsigned k = 0; k < hts_pkg::PEEK_N; k++) begin
            o_peek[k] = (CW'(k) < r_count) ? r_win[k] : 8'h00;
        end
    end

    assign o_status.full  = (r_count == CW'(LOOKAHEAD));
    assign o_status.empty = (r_count == '0);
    assign o_status.flush = r_flush;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LOOKAHEAD))
        else $error("window count beyond lookahead depth");

    a_no_push_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !i_push)
        else $error("byte taken while window flushes");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |-> (r_count == '0) && r_flush)
        else $error("end marker issued with bytes left in window");

endmodule

/* rtl/hts_decide.sv */
module hts_decide (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_clear,
    input  hts_pkg::t_peek    i_peek,
    output hts_pkg::t_result  o_res
);

    logic           r_strip;
    logic           r_quoted;
    logic           r_inside;
    logic           r_lws;
    hts_pkg::t_byte r_prev;
    logic [3:0]     r_skip;

    logic           n_strip;
    logic           n_quoted;
    logic           n_inside;
    logic           n_lws;
    logic [3:0]     n_skip;
    hts_pkg::t_byte c;
    hts_pkg::t_byte d;
    logic           ent_hit;
    hts_pkg::t_byte ent_rep;
    logic [3:0]     ent_skip;

    assign c = i_peek[0];
    assign d = i_peek[3];

    always_comb begin
        ent_hit  = 1'b0;
        ent_rep  = 8'h00;
        ent_skip = '0;
        for (int k = hts_pkg::ENT_N - 1; k >= 0; k--) begin
            if (hts_pkg::match_at(i_peek, 1, hts_pkg::ENT_NAME[k], hts_pkg::ENT_LEN[k])) begin
                ent_hit  = 1'b1;
                ent_rep  = hts_pkg::ENT_REP[k];
                ent_skip = 4'(hts_pkg::ENT_LEN[k])
                         + 4'(i_peek[1 + hts_pkg::ENT_LEN[k]] == hts_pkg::CH_SEMI);
            end
        end
    end

    always_comb begin
        n_strip  = r_strip;
        n_quoted = r_quoted;
        n_inside = r_inside;
        n_lws    = r_lws;
        n_skip   = r_skip;
        o_res    = '0;
        if (r_skip != '0) begin
            n_skip = r_skip - 4'd1;
        end else if (!r_quoted && !r_strip && c == hts_pkg::CH_LT) begin
            if (hts_pkg::match_at(i_peek, 0, "<html", 5)
                || hts_pkg::match_at(i_peek, 0, "<!DOCTYPE", 9)
                || hts_pkg::match_at(i_peek, 0, "<!--", 4)) begin
                n_inside = 1'b1;
                n_strip  = 1'b1;
            end else if (hts_pkg::match_at(i_peek, 0, "</html>", 7)) begin
                n_inside = 1'b0;
                n_strip  = 1'b1;
            end else if (!r_inside && i_peek[1] == hts_pkg::CH_SLASH) begin
                n_inside = 1'b1;
                n_strip  = 1'b1;
            end else if (r_inside) begin
                n_strip = 1'b1;
                if (hts_pkg::match_at(i_peek, 0, "<b>", 3)
                    || hts_pkg::match_at(i_peek, 0, "</b>", 4)) begin
                    o_res = '{has_char: 1'b1, ch: hts_pkg::CH_STAR};
                end else if (hts_pkg::match_at(i_peek, 0, "<i>", 3)
                    || hts_pkg::match_at(i_peek, 0, "</i>", 4)) begin
                    o_res = '{has_char: 1'b1, ch: hts_pkg::CH_SLASH};
                end else if (hts_pkg::match_at(i_peek, 0, "<u>", 3)
                    || hts_pkg::match_at(i_peek, 0, "</u>", 4)) begin
                    o_res = '{has_char: 1'b1, ch: hts_pkg::CH_UNDER};
                end else if ((hts_pkg::match_at(i_peek, 0, "</h", 3)
                        && d >= hts_pkg::CH_ZERO && d <= hts_pkg::CH_NINE)
                    || hts_pkg::match_at(i_peek, 0, "</p>", 4)
                    || hts_pkg::match_at(i_peek, 0, "</tr>", 5)
                    || hts_pkg::match_at(i_peek, 0, "</div>", 6)
                    || hts_pkg::match_at(i_peek, 0, "<br>", 4)) begin
                    o_res = '{has_char: 1'b1, ch: hts_pkg::CH_CR};
                end
            end else begin
                o_res = '{has_char: 1'b1, ch: hts_pkg::CH_LT};
            end
        end else if (!r_strip && !r_inside) begin
            o_res = '{has_char: 1'b1, ch: c};
        end else if (r_strip && !r_quoted && c == hts_pkg::CH_GT) begin
            n_strip = 1'b0;
        end else if (!r_inside) begin
            o_res = '0;
        end else if (r_strip) begin
            if (c == hts_pkg::CH_QUOTE) begin
                n_quoted = !r_quoted;
            end
        end else if (hts_pkg::is_blank(c)) begin
            if (r_prev == hts_pkg::CH_EQ) begin
                o_res = '{has_char: 1'b1, ch: c};
            end else if (!r_lws) begin
                o_res = '{has_char: 1'b1, ch: hts_pkg::CH_SPACE};
            end
            n_lws = 1'b1;
        end else begin
            n_lws = 1'b0;
            if (c == hts_pkg::CH_AMP && ent_hit) begin
                o_res  = '{has_char: 1'b1, ch: ent_rep};
                n_skip = ent_skip;
            end else begin
                o_res = '{has_char: 1'b1, ch: c};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_strip  <= 1'b0;
            r_quoted <= 1'b0;
            r_inside <= 1'b0;
            r_lws    <= 1'b1;
            r_prev   <= 8'h00;
            r_skip   <= '0;
        end else if (i_adv) begin
            r_strip  <= n_strip;
            r_quoted <= n_quoted;
            r_inside <= n_inside;
            r_lws    <= n_lws;
            r_prev   <= c;
            r_skip   <= n_skip;
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       text_end;
    } t_plain_item;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] in_byte
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic [0:0] o_m_tuser;   // [0] out_valid
    logic       o_m_tlast;

    html_tag_stripper_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Stripper state as seen from outside.
    logic [7:0]  look_win [16];
    int unsigned win_cnt;
    bit          strip_on;
    bit          quoted_on;
    bit          html_on;
    bit          was_space;
    logic [7:0]  prev_ch;
    int unsigned skip_left;
    bit          keep_plain;

    t_plain_item plain_q [$];
    t_plain_item want;
    logic [7:0]  text_bytes [$];

    int          mismatches;
    int          texts_sent;
    int          bytes_sent;
    int          results_seen;
    bit          steady;

    string      ent_name [10] = '{"nbsp", "brvbar", "laquo", "shy", "raquo",
                                  "divide", "quot", "amp", "lt", "gt"};
    logic [7:0] ent_char [10] = '{8'h20, 8'h7C, 8'h3C, 8'h2D, 8'h3E,
                                  8'h2F, 8'h22, 8'h26, 8'h3C, 8'h3E};

    string tag_pool [24] = '{"<html>", "<HTML lang=\"en\">", "<!DOCTYPE x>", "<!-- ", "-->",
                             "</html>", "<b>", "</B>", "<i>", "</i>", "<u>", "</U>",
                             "</h1>", "</H9>", "</hx>", "</p>", "</tr>", "</div>",
                             "<br>", "<p>", "<a x=\"1>2\">", "<", ">", "</"};

    // In the directed texts a tilde stands for a zero byte.
    string dir_text [10] = '{
        "~\377A",
        "a<b>c",
        "Z",
        "x</y>z",
        "<HTML><b>B</B><I>i</i><u>u</U>",
        "<html>a  \t\nb=\tc</p>d<br></h3></H7x></tr></div>~",
        "<html>&nbsp;&brvbar&LAQUO;&shy&raquo;&divide;&quot&amp;&lt&gt;&x",
        "<!DOCTYPE html><a href=\"x>y\">t</a>",
        "<!-- c -->k</html>k<q",
        "<html>\177\001 \200"
    };
    string dir_want [10] = '{"~\377A", "a<b>c", "Z", "", "", "", "", "", "", ""};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [7:0] up_char(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] peek_at(int unsigned off);
        return (off < win_cnt && off < 16) ? look_win[off] : 8'h00;
    endfunction

    function automatic bit seen(string pat, int unsigned off);
        for (int k = 0; k < pat.len(); k++) begin
            if (up_char(peek_at(off + k)) != up_char(pat[k])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int open_markup();
        logic [7:0] d;
        d = peek_at(3);
        if (seen("<html", 0) || seen("<!DOCTYPE", 0) || seen("<!--", 0)) begin
            html_on = 1'b1;
            strip_on = 1'b1;
        end else if (seen("</html>", 0)) begin
            html_on = 1'b0;
            strip_on = 1'b1;
        end else if (!html_on && peek_at(1) == hts_pkg::CH_SLASH) begin
            html_on = 1'b1;
            strip_on = 1'b1;
        end else if (html_on) begin
            strip_on = 1'b1;
            if (seen("<b>", 0) || seen("</b>", 0)) return int'(hts_pkg::CH_STAR);
            if (seen("<i>", 0) || seen("</i>", 0)) return int'(hts_pkg::CH_SLASH);
            if (seen("<u>", 0) || seen("</u>", 0)) return int'(hts_pkg::CH_UNDER);
            if ((seen("</h", 0) && d >= hts_pkg::CH_ZERO && d <= hts_pkg::CH_NINE) ||
                seen("</p>", 0) || seen("</tr>", 0) || seen("</div>", 0) ||
                seen("<br>", 0)) begin
                return int'(hts_pkg::CH_CR);
            end
        end else begin
            return int'(hts_pkg::CH_LT);
        end
        return -1;
    endfunction

    function automatic int judge_head(logic [7:0] c);
        int r;
        int unsigned len;
        if (skip_left > 0) begin
            skip_left--;
            return -1;
        end
        if (!quoted_on && !strip_on && c == hts_pkg::CH_LT) return open_markup();
        if (!strip_on && !html_on) return int'(c);
        if (strip_on && !quoted_on && c == hts_pkg::CH_GT) begin
            strip_on = 1'b0;
            return -1;
        end
        if (!html_on) return -1;
        if (strip_on) begin
            if (c == hts_pkg::CH_QUOTE) quoted_on = !quoted_on;
            return -1;
        end
        if (c < 8'd32 || c == hts_pkg::CH_DEL || c == hts_pkg::CH_SPACE) begin
            r = -1;
            if (prev_ch == hts_pkg::CH_EQ) r = int'(c);
            else if (!was_space) r = int'(hts_pkg::CH_SPACE);
            was_space = 1'b1;
            return r;
        end
        was_space = 1'b0;
        if (c == hts_pkg::CH_AMP) begin
            for (int k = 0; k < 10; k++) begin
                if (seen(ent_name[k], 1)) begin
                    len = ent_name[k].len();
                    skip_left = len + ((peek_at(1 + len) == hts_pkg::CH_SEMI) ? 1 : 0);
                    return int'(ent_char[k]);
                end
            end
        end
        return int'(c);
    endfunction

    task automatic clear_stripper();
        for (int k = 0; k < 16; k++) look_win[k] = 8'h00;
        win_cnt = 0;
        strip_on = 1'b0;
        quoted_on = 1'b0;
        html_on = 1'b0;
        was_space = 1'b1;
        prev_ch = 8'h00;
        skip_left = 0;
    endtask

    task automatic decide_head();
        logic [7:0] c;
        int r;
        c = look_win[0];
        r = judge_head(c);
        for (int k = 0; k < 15; k++) look_win[k] = look_win[k + 1];
        look_win[15] = 8'h00;
        if (win_cnt > 0) win_cnt--;
        prev_ch = c;
        if (r >= 0 && keep_plain) plain_q.push_back(t_plain_item'{r[7:0], 1'b1, 1'b0});
    endtask

    task automatic strip_text_byte(logic [7:0] b, logic last);
        while (win_cnt >= hts_pkg::LOOKAHEAD_DEF) decide_head();
        look_win[win_cnt] = b;
        win_cnt++;
        if (!last) begin
            while (win_cnt >= hts_pkg::LOOKAHEAD_DEF) decide_head();
        end else begin
            while (win_cnt > 0) decide_head();
            if (keep_plain) plain_q.push_back(t_plain_item'{8'h00, 1'b0, 1'b1});
            clear_stripper();
        end
    endtask

    task automatic flag_mismatch(string msg);
        if (mismatches < 30) $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int draw_wait();
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        strip_text_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text();
        steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < text_bytes.size(); k++) begin
            send_byte(text_bytes[k], k == text_bytes.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic add_str(string s, bit mixed);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if (mixed && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1))
                c = c ^ 8'h20;
            text_bytes.push_back(c);
        end
    endtask

    task automatic add_blanks();
        logic [7:0] pick [8] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h00, 8'h7F, 8'h01, 8'h1F};
        int n;
        n = $urandom_range(1, 4);
        repeat (n) text_bytes.push_back(pick[$urandom_range(0, 7)]);
    endtask

    task automatic build_text();
        int ntok;
        int n;
        text_bytes.delete();
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: add_str("<html>", 1'b1);
            5:             add_str("<!DOCTYPE html>", 1'b1);
            6:             add_str("<!-- x -->", 1'b0);
            default:       ;
        endcase
        ntok = $urandom_range(1, 14);
        repeat (ntok) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    n = $urandom_range(1, 6);
                    repeat (n) text_bytes.push_back(8'($urandom_range(0, 3) == 0 ?
                        $urandom_range(128, 255) : $urandom_range(8'h61, 8'h7A)));
                end
                2, 3: add_str(tag_pool[$urandom_range(0, 23)], 1'b1);
                4: begin
                    add_str("&", 1'b0);
                    add_str($urandom_range(0, 5) == 0 ? "foo" : ent_name[$urandom_range(0, 9)],
                            1'b1);
                    if ($urandom_range(0, 1)) add_str(";", 1'b0);
                end
                5: add_blanks();
                6: begin
                    add_str("=", 1'b0);
                    add_blanks();
                end
                7: add_str("\"", 1'b0);
                8: text_bytes.push_back(8'($urandom_range(0, 255)));
                default: add_str("</html>", 1'b1);
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (plain_q.size() == 0) begin
                flag_mismatch($sformatf("result %02h/%0b/%0b with nothing expected",
                                        o_m_tdata, o_m_tuser[0], o_m_tlast));
            end else begin
                want = plain_q.pop_front();
                if (o_m_tdata !== want.ch)
                    flag_mismatch($sformatf("out_byte %02h, expected %02h", o_m_tdata, want.ch));
                if (o_m_tuser[0] !== want.has_char)
                    flag_mismatch($sformatf("out_valid %b, expected %b",
                                            o_m_tuser[0], want.has_char));
                if (o_m_tlast !== want.text_end)
                    flag_mismatch($sformatf("out_end %b, expected %b", o_m_tlast, want.text_end));
            end
        end
    end

    initial begin
        int stall;
        i_m_tready <= 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        logic [7:0] c;
        mismatches = 0;
        texts_sent = 0;
        bytes_sent = 0;
        results_seen = 0;
        steady = 1'b0;
        keep_plain = 1'b1;
        clear_stripper();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tlast  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < 10; row++) begin
            text_bytes.delete();
            for (int k = 0; k < dir_text[row].len(); k++) begin
                c = dir_text[row][k];
                text_bytes.push_back(c == 8'h7E ? 8'h00 : c);
            end
            keep_plain = (dir_want[row].len() == 0);
            if (!keep_plain) begin
                for (int k = 0; k < dir_want[row].len(); k++) begin
                    c = dir_want[row][k];
                    plain_q.push_back(t_plain_item'{c == 8'h7E ? 8'h00 : c, 1'b1, 1'b0});
                end
                plain_q.push_back(t_plain_item'{8'h00, 1'b0, 1'b1});
            end
            send_text();
        end
        keep_plain = 1'b1;

        while (bytes_sent < 410) begin
            build_text();
            send_text();
        end
        i_s_tvalid <= 1'b0;

        while (plain_q.size() != 0) @(posedge i_clk);
        repeat (hts_pkg::LOOKAHEAD_DEF + 8) @(posedge i_clk);

        $display("Sent %0d texts (%0d bytes) of plain text, html markup and entities;",
                 texts_sent, bytes_sent);
        $display("compared %0d output results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
